[hw/rtl/s128alu_pkg.sv]
`timescale 1ns / 1ps
package s128alu_pkg;

	localparam int DATA_W        = 128;
	localparam int HALF_W        = 64;
	localparam int FUNC_W        = 4;
	localparam int SHAMT_W       = 7;
	localparam int DEFAULT_WIDTH = 128;

	localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd0;
	localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd1;
	localparam logic [FUNC_W-1:0] FUNC_MUL = 4'd2;
	localparam logic [FUNC_W-1:0] FUNC_DIV = 4'd3;
	localparam logic [FUNC_W-1:0] FUNC_SHL = 4'd4;
	localparam logic [FUNC_W-1:0] FUNC_SAR = 4'd5;
	localparam logic [FUNC_W-1:0] FUNC_ROL = 4'd6;
	localparam logic [FUNC_W-1:0] FUNC_ROR = 4'd7;
	localparam logic [FUNC_W-1:0] FUNC_AND = 4'd8;
	localparam logic [FUNC_W-1:0] FUNC_OR  = 4'd9;
	localparam logic [FUNC_W-1:0] FUNC_XOR = 4'd10;
	localparam logic [FUNC_W-1:0] FUNC_NOT = 4'd11;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              neg;
		logic              dz;
		logic              ovf;
	} ctl_t;

endpackage

[hw/rtl/s128alu_prep.sv]
`timescale 1ns / 1ps
module s128alu_prep import s128alu_pkg::*; #(
	parameter int WIDTH = DEFAULT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [FUNC_W-1:0]   func,
	input  logic [HALF_W-1:0]   a_hi,
	input  logic [HALF_W-1:0]   a_lo,
	input  logic [HALF_W-1:0]   b_hi,
	input  logic [HALF_W-1:0]   b_lo,
	input  logic [SHAMT_W-1:0]  shift_amount,
	output logic                valid_s1,
	output ctl_t                ctl_s1,
	output logic [WIDTH-1:0]    a_mag_s1,
	output logic [WIDTH-1:0]    b_mag_s1,
	output logic [2*WIDTH-1:0]  work_s1
);

	logic [DATA_W-1:0] a128, b128;
	logic [WIDTH-1:0]  a_w, b_w, sum_w, diff_w, res_w, a_mag, b_mag;
	logic              sa, sb;
	ctl_t              ctl;

	assign a128 = {a_hi, a_lo};
	assign b128 = {b_hi, b_lo};

	generate
		if (WIDTH > DATA_W) begin : g_ext
			assign a_w = {{(WIDTH-DATA_W){a128[DATA_W-1]}}, a128};
			assign b_w = {{(WIDTH-DATA_W){b128[DATA_W-1]}}, b128};
		end else begin : g_cut
			assign a_w = a128[WIDTH-1:0];
			assign b_w = b128[WIDTH-1:0];
		end
	endgenerate

	assign sa     = a_w[WIDTH-1];
	assign sb     = b_w[WIDTH-1];
	assign sum_w  = a_w + b_w;
	assign diff_w = a_w - b_w;
	assign a_mag  = sa ? (~a_w + 1'b1) : a_w;
	assign b_mag  = sb ? (~b_w + 1'b1) : b_w;

	always_comb begin
		ctl.func = func;
		ctl.neg  = sa ^ sb;
		ctl.dz   = (func == FUNC_DIV) && (b_w == '0);
		ctl.ovf  = 1'b0;
		res_w    = '0;
		case (func)
			FUNC_ADD: begin
				res_w   = sum_w;
				ctl.ovf = (sa == sb) && (sum_w[WIDTH-1] != sa);
			end
			FUNC_SUB: begin
				res_w   = diff_w;
				ctl.ovf = (sa != sb) && (diff_w[WIDTH-1] != sa);
			end
			FUNC_SHL: res_w = a_w << shift_amount;
			FUNC_SAR: res_w = $signed(a_w) >>> shift_amount;
			FUNC_ROL: res_w = {a_w[WIDTH-2:0], a_w[WIDTH-1]};
			FUNC_ROR: res_w = {a_w[0], a_w[WIDTH-1:1]};
			FUNC_AND: res_w = a_w & b_w;
			FUNC_OR:  res_w = a_w | b_w;
			FUNC_XOR: res_w = a_w ^ b_w;
			FUNC_NOT: res_w = ~a_w;
			default:  res_w = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// multiply and divide start from a cleared accumulator
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl;
			a_mag_s1 <= a_mag;
			b_mag_s1 <= b_mag;
			work_s1  <= ((func == FUNC_MUL) || (func == FUNC_DIV)) ? '0 :
				{{WIDTH{1'b0}}, res_w};
		end
	end

endmodule

[hw/rtl/s128alu_step.sv]
`timescale 1ns / 1ps
module s128alu_step import s128alu_pkg::*; #(
	parameter int WIDTH = DEFAULT_WIDTH,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_d,
	input  ctl_t                ctl_d,
	input  logic [WIDTH-1:0]    a_mag_d,
	input  logic [WIDTH-1:0]    b_mag_d,
	input  logic [2*WIDTH-1:0]  work_d,
	output logic                valid_s,
	output ctl_t                ctl_s,
	output logic [WIDTH-1:0]    a_mag_s,
	output logic [WIDTH-1:0]    b_mag_s,
	output logic [2*WIDTH-1:0]  work_s
);

	localparam int BIT = WIDTH - 1 - IDX;

	logic [2*WIDTH-1:0] prod;
	logic [WIDTH-1:0]   rem_sh, rem_sub;
	logic               ge;
	logic [2*WIDTH-1:0] work_nx;

	// multiply: shift-add over magnitude bits of b, msb first
	assign prod = {work_d[2*WIDTH-2:0], 1'b0} +
		(b_mag_d[BIT] ? {{WIDTH{1'b0}}, a_mag_d} : {(2*WIDTH){1'b0}});

	// divide: restoring step, remainder in upper half, quotient shifts into lower half
	assign rem_sh  = {work_d[2*WIDTH-2:WIDTH], a_mag_d[BIT]};
	assign ge      = rem_sh >= b_mag_d;
	assign rem_sub = rem_sh - b_mag_d;

	always_comb begin
		case (ctl_d.func)
			FUNC_MUL: work_nx = prod;
			FUNC_DIV: work_nx = {(ge ? rem_sub : rem_sh), work_d[WIDTH-2:0], ge};
			default:  work_nx = work_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s   <= ctl_d;
			a_mag_s <= a_mag_d;
			b_mag_s <= b_mag_d;
			work_s  <= work_nx;
		end
	end

endmodule

[hw/rtl/s128alu_post.sv]
`timescale 1ns / 1ps
module s128alu_post import s128alu_pkg::*; #(
	parameter int WIDTH = DEFAULT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_d,
	input  ctl_t                ctl_d,
	input  logic [2*WIDTH-1:0]  work_d,
	output logic                out_valid,
	output logic [HALF_W-1:0]   result_hi,
	output logic [HALF_W-1:0]   result_lo,
	output logic                overflow,
	output logic                divide_by_zero
);

	logic [WIDTH-1:0]  low_w, neg_w, res_w;
	logic [DATA_W-1:0] res128;
	logic              ovf, p_ge, p_eq;

	assign low_w = work_d[WIDTH-1:0];
	assign neg_w = ~low_w + 1'b1;

	// product magnitude against 2^(WIDTH-1)
	assign p_ge = |work_d[2*WIDTH-1:WIDTH-1];
	assign p_eq = (work_d[2*WIDTH-1:WIDTH] == '0) && work_d[WIDTH-1] &&
		(work_d[WIDTH-2:0] == '0);

	always_comb begin
		res_w = low_w;
		ovf   = ctl_d.ovf;
		case (ctl_d.func)
			FUNC_MUL: begin
				res_w = ctl_d.neg ? neg_w : low_w;
				ovf   = ctl_d.neg ? (p_ge && !p_eq) : p_ge;
			end
			FUNC_DIV: begin
				if (ctl_d.dz) begin
					res_w = '0;
					ovf   = 1'b0;
				end else begin
					res_w = ctl_d.neg ? neg_w : low_w;
					ovf   = !ctl_d.neg && low_w[WIDTH-1];
				end
			end
			default: begin
				res_w = low_w;
				ovf   = ctl_d.ovf;
			end
		endcase
	end

	generate
		if (WIDTH >= DATA_W) begin : g_cut
			assign res128 = res_w[DATA_W-1:0];
		end else begin : g_ext
			assign res128 = {{(DATA_W-WIDTH){res_w[WIDTH-1]}}, res_w};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_hi      <= res128[DATA_W-1:HALF_W];
			result_lo      <= res128[HALF_W-1:0];
			overflow       <= ovf;
			divide_by_zero <= ctl_d.dz;
		end
	end

endmodule

[hw/rtl/signed_128bit_integer_alu_core.sv]
`timescale 1ns / 1ps
// channel  | handshake          | payload
// request  | in_valid, in_stall | func, a_hi, a_lo, b_hi, b_lo, shift_amount
// result   | out_valid, out_stall | result_hi, result_lo, overflow, divide_by_zero
//
// one request per cycle while in_stall is low; each accepted request passes through
// an operand stage, one shift-add or restoring-divide stage per bit and an output
// stage, in that order, before its result appears
// the per-bit stage chain sets the latency; all operations travel the same chain
// reset clears the valid bits only
// a held result stalls the whole chain; in_stall is high exactly then
module signed_128bit_integer_alu_core import s128alu_pkg::*; #(
	parameter int WIDTH = DEFAULT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [HALF_W-1:0]   a_hi,
	input  logic [HALF_W-1:0]   a_lo,
	input  logic [HALF_W-1:0]   b_hi,
	input  logic [HALF_W-1:0]   b_lo,
	input  logic [SHAMT_W-1:0]  shift_amount,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HALF_W-1:0]   result_hi,
	output logic [HALF_W-1:0]   result_lo,
	output logic                overflow,
	output logic                divide_by_zero
);

	logic               en;
	logic               valid_s [0:WIDTH];
	ctl_t               ctl_s   [0:WIDTH];
	logic [WIDTH-1:0]   a_mag_s [0:WIDTH];
	logic [WIDTH-1:0]   b_mag_s [0:WIDTH];
	logic [2*WIDTH-1:0] work_s  [0:WIDTH];

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	s128alu_prep #(.WIDTH(WIDTH)) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.func         (func),
		.a_hi         (a_hi),
		.a_lo         (a_lo),
		.b_hi         (b_hi),
		.b_lo         (b_lo),
		.shift_amount (shift_amount),
		.valid_s1     (valid_s[0]),
		.ctl_s1       (ctl_s[0]),
		.a_mag_s1     (a_mag_s[0]),
		.b_mag_s1     (b_mag_s[0]),
		.work_s1      (work_s[0])
	);

	generate
		for (genvar k = 0; k < WIDTH; k++) begin : g_step
			s128alu_step #(.WIDTH(WIDTH), .IDX(k)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.valid_d (valid_s[k]),
				.ctl_d   (ctl_s[k]),
				.a_mag_d (a_mag_s[k]),
				.b_mag_d (b_mag_s[k]),
				.work_d  (work_s[k]),
				.valid_s (valid_s[k+1]),
				.ctl_s   (ctl_s[k+1]),
				.a_mag_s (a_mag_s[k+1]),
				.b_mag_s (b_mag_s[k+1]),
				.work_s  (work_s[k+1])
			);
		end
	endgenerate

	s128alu_post #(.WIDTH(WIDTH)) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_d        (valid_s[WIDTH]),
		.ctl_d          (ctl_s[WIDTH]),
		.work_d         (work_s[WIDTH]),
		.out_valid      (out_valid),
		.result_hi      (result_hi),
		.result_lo      (result_lo),
		.overflow       (overflow),
		.divide_by_zero (divide_by_zero)
	);

endmodule

[bench/alu_checker.sv]
`timescale 1ns / 1ps
module alu_checker import s128alu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [FUNC_W-1:0]  func,
	input  logic [HALF_W-1:0]  a_hi,
	input  logic [HALF_W-1:0]  a_lo,
	input  logic [HALF_W-1:0]  b_hi,
	input  logic [HALF_W-1:0]  b_lo,
	input  logic [SHAMT_W-1:0] shift_amount,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [HALF_W-1:0]  result_hi,
	input  logic [HALF_W-1:0]  result_lo,
	input  logic               overflow,
	input  logic               divide_by_zero,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              ovf;
		logic              dz;
	} alu_result_t;

	alu_result_t expected_results[$];
	int          mismatch_count;

	assign fail_count = mismatch_count;

	function automatic alu_result_t compute_alu(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [SHAMT_W-1:0] sh);
		alu_result_t       r;
		logic signed [DATA_W:0]     wide_sum;
		logic signed [2*DATA_W-1:0] prod;
		logic [DATA_W-1:0]          ua, ub, q;
		r.value = '0;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		case (op)
			FUNC_ADD: begin
				wide_sum = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
				r.value = wide_sum[DATA_W-1:0];
				r.ovf = wide_sum[DATA_W] != wide_sum[DATA_W-1];
			end
			FUNC_SUB: begin
				wide_sum = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
				r.value = wide_sum[DATA_W-1:0];
				r.ovf = wide_sum[DATA_W] != wide_sum[DATA_W-1];
			end
			FUNC_MUL: begin
				prod = $signed(a) * $signed(b);
				r.value = prod[DATA_W-1:0];
				// exact product must be the sign extension of its low half
				r.ovf = prod[2*DATA_W-1:DATA_W] != {DATA_W{prod[DATA_W-1]}};
			end
			FUNC_DIV: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else begin
					ua = a[DATA_W-1] ? -a : a;
					ub = b[DATA_W-1] ? -b : b;
					q = ua / ub;
					if (a[DATA_W-1] != b[DATA_W-1]) begin
						r.value = -q;
					end else begin
						r.value = q;
						r.ovf = q[DATA_W-1];
					end
				end
			end
			FUNC_SHL: r.value = a << sh;
			FUNC_SAR: r.value = $signed(a) >>> sh;
			FUNC_ROL: r.value = {a[DATA_W-2:0], a[DATA_W-1]};
			FUNC_ROR: r.value = {a[0], a[DATA_W-1:1]};
			FUNC_AND: r.value = a & b;
			FUNC_OR:  r.value = a | b;
			FUNC_XOR: r.value = a ^ b;
			FUNC_NOT: r.value = ~a;
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			mismatch_count <= 0;
			result_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					compute_alu(func, {a_hi, a_lo}, {b_hi, b_lo}, shift_amount));
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result %h_%h", result_hi, result_lo);
				end else begin
					want = expected_results.pop_front();
					if ({result_hi, result_lo} !== want.value || overflow !== want.ovf
							|| divide_by_zero !== want.dz) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("mismatch: want %h ovf %b dz %b, got %h_%h ovf %b dz %b",
								want.value, want.ovf, want.dz, result_hi, result_lo,
								overflow, divide_by_zero);
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb import s128alu_pkg::*; ();

	localparam int RANDOM_REQUESTS = 1830;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MINUS_ONE = '1;
	// codes with no operation behind them
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd12;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [FUNC_W-1:0]  func;
	logic [HALF_W-1:0]  a_hi, a_lo, b_hi, b_lo;
	logic [SHAMT_W-1:0] shift_amount;
	logic               out_valid;
	logic               out_stall;
	logic [HALF_W-1:0]  result_hi, result_lo;
	logic               overflow, divide_by_zero;
	int                 fail_count, pending, result_count;
	int                 cycle_count = 0;
	int                 sent_count;

	signed_128bit_integer_alu_core i_dut (.*);

	alu_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int gap_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// receiver back-pressure, in bursts
	initial begin
		int stretch;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(299) == 0) begin
				stretch = $urandom_range(300, 100);
				repeat (stretch) @(negedge clk);
			end else begin
				out_stall <= gap_length() != 0 && $urandom_range(2) == 0;
			end
		end
	end

	function automatic logic [DATA_W-1:0] random_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(9))
			0: v = MOST_NEG;
			1: v = MOST_POS;
			2: v = MINUS_ONE;
			3: v = DATA_W'($urandom_range(3));
			4: v = -$signed({96'd0, 32'($urandom)});
			5: v = {{64{1'b0}}, $urandom, $urandom};
			default: v = {$urandom, $urandom, $urandom, $urandom};
		endcase
		return v;
	endfunction

	task automatic send_request(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [SHAMT_W-1:0] sh);
		in_valid <= 1'b1;
		func <= op;
		{a_hi, a_lo} <= a;
		{b_hi, b_lo} <= b;
		shift_amount <= sh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = gap_length();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		logic [FUNC_W-1:0] op;
		logic [DATA_W-1:0] a, b;
		sent_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_ADD;
		{a_hi, a_lo, b_hi, b_lo} = '0;
		shift_amount = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(FUNC_ADD, MOST_POS, 128'd1, 7'd0);
		send_request(FUNC_ADD, MOST_NEG, MINUS_ONE, 7'd0);
		send_request(FUNC_SUB, MOST_NEG, 128'd1, 7'd0);
		send_request(FUNC_SUB, 128'd0, MOST_NEG, 7'd0);
		send_request(FUNC_MUL, MOST_POS, MOST_POS, 7'd0);
		send_request(FUNC_MUL, MOST_NEG, MINUS_ONE, 7'd0);
		send_request(FUNC_MUL, MINUS_ONE, MINUS_ONE, 7'd0);
		send_request(FUNC_DIV, MOST_POS, 128'd0, 7'd0);
		send_request(FUNC_DIV, MOST_NEG, MINUS_ONE, 7'd0);
		send_request(FUNC_DIV, -128'sd7, 128'd2, 7'd0);
		send_request(FUNC_DIV, 128'd7, -128'sd2, 7'd0);
		send_request(FUNC_SHL, MINUS_ONE, '0, 7'd127);
		send_request(FUNC_SHL, MOST_POS, '0, 7'd0);
		send_request(FUNC_SAR, MOST_NEG, '0, 7'd127);
		send_request(FUNC_SAR, MOST_POS, '0, 7'd64);
		send_request(FUNC_ROL, MOST_NEG, '0, 7'd0);
		send_request(FUNC_ROR, 128'd1, '0, 7'd0);
		send_request(FUNC_AND, MINUS_ONE, MOST_POS, 7'd0);
		send_request(FUNC_OR, MOST_NEG, 128'd1, 7'd0);
		send_request(FUNC_XOR, MINUS_ONE, MOST_NEG, 7'd0);
		send_request(FUNC_NOT, 128'd0, '0, 7'd0);
		// unused operation codes
		send_request(FUNC_UNUSED_LO, MINUS_ONE, MINUS_ONE, 7'd127);
		send_request(FUNC_UNUSED_HI, MOST_NEG, 128'd5, 7'd3);

		repeat (RANDOM_REQUESTS) begin
			op = FUNC_W'($urandom_range(15));
			a = random_operand();
			b = random_operand();
			if (op == FUNC_DIV && $urandom_range(9) == 0) b = '0;
			send_request(op, a, b, SHAMT_W'($urandom_range(127)));
			idle_gap();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("%0d requests over all opcodes, %0d results checked", sent_count,
			result_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
